/* design/udsr_pkg.sv */
// Shared constants and beat types for the URL path dot-segment removal unit.
package udsr_pkg;

  // Store geometry
  localparam int PATH_BYTES = 1024;
  localparam int ADDR_W     = $clog2(PATH_BYTES);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int SUM_W      = CNT_W + 1;
  localparam int IDX_W      = 10;
  localparam int LEN_OUT_W  = 10;
  localparam int CMP_W      = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;

  // Characters
  localparam logic [7:0] SLASH_CHAR = 8'h2F;
  localparam logic [7:0] DOT_CHAR   = 8'h2E;

  // Request codes
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_PUSH  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Request beat
  typedef struct packed {
    logic [1:0]       req_type;
    logic [7:0]       path_byte;
    logic             last_byte;
    logic [IDX_W-1:0] read_index;
  } req_t;

  // Result beat
  typedef struct packed {
    logic [LEN_OUT_W-1:0] path_length;
    logic [7:0]           read_data;
    logic                 segment_dropped;
    logic                 path_complete;
  } res_t;

endpackage

/* design/udsr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module udsr_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write one entry, register the read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/url_path_dot_segment_removal_unit.sv */
// Top level of the streaming URL path dot-segment removal unit.
//
//  channel   | signals              | direction | handshake
//  ----------+----------------------+-----------+--------------------------------
//  request   | start_i, req_i       | in        | beat taken when start_i && !busy_o
//  status    | busy_o               | out       | high during a read or a ".." backscan
//  result    | valid_o, res_o       | out       | one-cycle strobe, never stalled
//
//  Start, push and unknown requests are answered in the cycle after accept, apart
//  from a ".." close that backs up. A read is answered through the registered read
//  port of the path store, then the result register. A ".." close walks back one
//  stored byte at a time, the stopping slash included (store read then slash compare).
//  Reset leaves the store uncleared; entry 0 is never written, a read of index 0 returns the root slash.
//  Results are shown for exactly one cycle; the receiver cannot stall them.
module url_path_dot_segment_removal_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  udsr_pkg::req_t  req_i,
  output logic            busy_o,
  output logic            valid_o,
  output udsr_pkg::res_t  res_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_SCAN_RD,
    ST_SCAN_CMP
  } state_e;

  typedef enum logic [1:0] {
    CLS_EMPTY,
    CLS_ONE_DOT,
    CLS_TWO_DOTS,
    CLS_PLAIN
  } cls_e;

  state_e                        state_q, state_d;
  cls_e                          cls_q, cls_d, cls_n, close_cls;
  logic [udsr_pkg::ADDR_W-1:0]   fill_q, fill_d;
  logic [udsr_pkg::CNT_W-1:0]    seglen_q, seglen_d, len_n;
  logic                          drop_q, drop_d;
  logic                          done_q, done_d;
  logic                          valid_q, valid_d;
  logic [7:0]                    rd_data_q, rd_data_d;
  logic                          rd_hit_q, rd_hit_d;
  logic                          rd_zero_q, rd_zero_d;

  logic                          accept;
  logic                          push_ok;
  logic                          is_slash;
  logic                          is_dot;
  logic                          closing;
  logic                          room;
  logic [udsr_pkg::SUM_W-1:0]    sum;
  logic [udsr_pkg::CMP_W-1:0]    idx_ext;
  logic [udsr_pkg::CMP_W-1:0]    fill_ext;

  logic                          mem_we;
  logic [udsr_pkg::ADDR_W-1:0]   mem_waddr;
  logic [7:0]                    mem_wdata;
  logic [udsr_pkg::ADDR_W-1:0]   mem_raddr;
  logic [7:0]                    mem_rdata;

  // Decode the request beat
  assign accept   = start_i && (state_q == ST_IDLE);
  assign push_ok  = accept && (req_i.req_type == udsr_pkg::REQ_PUSH) && !done_q;
  assign is_slash = (req_i.path_byte == udsr_pkg::SLASH_CHAR);
  assign is_dot   = (req_i.path_byte == udsr_pkg::DOT_CHAR);
  assign closing  = push_ok && (is_slash || req_i.last_byte);

  // Open segment end position, shared by the byte write and the room check
  assign sum = udsr_pkg::SUM_W'(fill_q) + udsr_pkg::SUM_W'(seglen_q);

  // Saturating segment length after one more byte
  assign len_n = (seglen_q == udsr_pkg::CNT_W'(udsr_pkg::PATH_BYTES)) ?
                 seglen_q : seglen_q + 1'b1;

  // Classify the segment after this byte
  always_comb begin
    priority if (cls_q == CLS_EMPTY && is_dot) begin
      cls_n = CLS_ONE_DOT;
    end else if (cls_q == CLS_ONE_DOT && is_dot) begin
      cls_n = CLS_TWO_DOTS;
    end else begin
      cls_n = CLS_PLAIN;
    end
  end

  assign close_cls = is_slash ? cls_q : cls_n;

  // Keep a closed segment only if it plus one byte fits below the store end
  assign room = is_slash ? (sum < udsr_pkg::SUM_W'(udsr_pkg::PATH_BYTES - 1)) :
                           (sum < udsr_pkg::SUM_W'(udsr_pkg::PATH_BYTES - 2));

  // Store write: segment byte at its place, or the closing slash
  assign mem_waddr = sum[udsr_pkg::ADDR_W-1:0];
  assign mem_wdata = is_slash ? udsr_pkg::SLASH_CHAR : req_i.path_byte;
  assign mem_we    = push_ok &&
                     (is_slash ? (cls_q == CLS_PLAIN && room) :
                                 (sum < udsr_pkg::SUM_W'(udsr_pkg::PATH_BYTES)));

  // Read range check and read address
  assign idx_ext   = udsr_pkg::CMP_W'(req_i.read_index);
  assign fill_ext  = udsr_pkg::CMP_W'(fill_q);
  assign mem_raddr = (state_q == ST_IDLE) ? idx_ext[udsr_pkg::ADDR_W-1:0] :
                                            fill_q - 1'b1;

  udsr_ram #(
    .Width (8),
    .Depth (udsr_pkg::PATH_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Sequencer next state
  always_comb begin
    state_d   = state_q;
    cls_d     = cls_q;
    fill_d    = fill_q;
    seglen_d  = seglen_q;
    drop_d    = drop_q;
    done_d    = done_q;
    valid_d   = 1'b0;
    rd_data_d = rd_data_q;
    rd_hit_d  = rd_hit_q;
    rd_zero_d = rd_zero_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rd_data_d = '0;
          valid_d   = 1'b1;
          priority if (req_i.req_type == udsr_pkg::REQ_START) begin
            fill_d   = udsr_pkg::ADDR_W'(1);
            seglen_d = '0;
            cls_d    = CLS_EMPTY;
            drop_d   = 1'b0;
            done_d   = 1'b0;
          end else if (req_i.req_type == udsr_pkg::REQ_READ) begin
            // Hold the result until the store read returns
            valid_d   = 1'b0;
            rd_hit_d  = (idx_ext < fill_ext);
            rd_zero_d = (req_i.read_index == '0);
            state_d   = ST_RD_WAIT;
          end else if (push_ok) begin
            if (req_i.last_byte) begin
              done_d = 1'b1;
            end
            if (closing) begin
              seglen_d = '0;
              cls_d    = CLS_EMPTY;
              unique case (close_cls)
                CLS_PLAIN: begin
                  if (room) begin
                    fill_d = sum[udsr_pkg::ADDR_W-1:0] + 1'b1;
                  end else begin
                    drop_d = 1'b1;
                  end
                end
                CLS_TWO_DOTS: begin
                  // Back up past the last stored slash, then walk to the previous one
                  if (fill_q > udsr_pkg::ADDR_W'(1)) begin
                    fill_d = fill_q - 1'b1;
                    if (fill_q > udsr_pkg::ADDR_W'(2)) begin
                      valid_d = 1'b0;
                      state_d = ST_SCAN_RD;
                    end
                  end
                end
                default: begin
                end
              endcase
            end else begin
              seglen_d = len_n;
              cls_d    = cls_n;
            end
          end else begin
          end
        end
      end
      ST_RD_WAIT: begin
        rd_data_d = rd_hit_q ? (rd_zero_q ? udsr_pkg::SLASH_CHAR : mem_rdata) : '0;
        valid_d   = 1'b1;
        state_d   = ST_IDLE;
      end
      ST_SCAN_RD: begin
        state_d = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        // Drop one byte unless it is the slash that ends the previous segment
        if (mem_rdata != udsr_pkg::SLASH_CHAR) begin
          fill_d = fill_q - 1'b1;
          if (fill_q > udsr_pkg::ADDR_W'(2)) begin
            state_d = ST_SCAN_RD;
          end else begin
            valid_d = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cls_q     <= CLS_EMPTY;
      fill_q    <= udsr_pkg::ADDR_W'(1);
      seglen_q  <= '0;
      drop_q    <= 1'b0;
      done_q    <= 1'b0;
      valid_q   <= 1'b0;
      rd_data_q <= '0;
      rd_hit_q  <= 1'b0;
      rd_zero_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cls_q     <= cls_d;
      fill_q    <= fill_d;
      seglen_q  <= seglen_d;
      drop_q    <= drop_d;
      done_q    <= done_d;
      valid_q   <= valid_d;
      rd_data_q <= rd_data_d;
      rd_hit_q  <= rd_hit_d;
      rd_zero_q <= rd_zero_d;
    end
  end

  assign busy_o                = (state_q != ST_IDLE);
  assign valid_o               = valid_q;
  assign res_o.path_length     = udsr_pkg::LEN_OUT_W'(fill_q);
  assign res_o.read_data       = rd_data_q;
  assign res_o.segment_dropped = drop_q;
  assign res_o.path_complete   = done_q;

`ifndef SYNTH
  // A result beat only leaves once the sequencer is back to idle
  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o)
    else $error("result strobe while busy");

  // The normalized path always keeps the root: its length never drops to zero
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != '0)
    else $error("path length dropped to zero");

  // A start beat is answered next cycle with a fresh root-only path
  a_start_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_i.req_type == udsr_pkg::REQ_START) |=>
    (valid_o && res_o.path_length == udsr_pkg::LEN_OUT_W'(1) &&
     !res_o.segment_dropped && !res_o.path_complete))
    else $error("start not answered with fresh path");

  // The backscan never walks below the root slash
  a_scan_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN_RD) |-> (fill_q > udsr_pkg::ADDR_W'(1)))
    else $error("backscan below root");
`endif

endmodule
